@@ rtl/assert_macros.svh @@
// Assertion macros shared by the compositor RTL.
// Depends on nothing; users supply clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted
`define GFPC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication, consequent checked in the cycle after the antecedent
`define GFPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/gfpc_pkg.sv @@
// Package for the GIF frame pixel compositor: operation codes, register
// indexes, queue entry type and the interlace pass tables. No dependencies.
package gfpc_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_PIXEL = 2'd1,
		OP_START = 2'd2
	} op_t;

	localparam logic [2:0] REG_LEFT      = 3'd0;
	localparam logic [2:0] REG_TOP       = 3'd1;
	localparam logic [2:0] REG_WIDTH     = 3'd2;
	localparam logic [2:0] REG_HEIGHT    = 3'd3;
	localparam logic [2:0] REG_INTERLACE = 3'd4;
	localparam logic [2:0] REG_TMODE     = 3'd5;
	localparam logic [2:0] REG_TINDEX    = 3'd6;
	localparam logic [2:0] REG_BGINDEX   = 3'd7;

	localparam logic [1:0] TM_NONE = 2'd0;
	localparam int         TM_SKIP_BIT = 1;

	// One queued transfer from front to back: a palette load or a pixel
	typedef struct packed {
		logic        is_load;
		logic        oob;
		logic [7:0]  index;
		logic [23:0] rgb;
		logic        we;
		logic [16:0] pos_x;
		logic [16:0] pos_y;
		logic        done;
	} queue_t;

	function automatic logic [15:0] pass_start(input logic [1:0] p);
		case (p)
			2'd0:    pass_start = 16'd0;
			2'd1:    pass_start = 16'd4;
			2'd2:    pass_start = 16'd2;
			default: pass_start = 16'd1;
		endcase
	endfunction

	function automatic logic [15:0] pass_step(input logic [1:0] p);
		case (p)
			2'd0:    pass_step = 16'd8;
			2'd1:    pass_step = 16'd8;
			2'd2:    pass_step = 16'd4;
			default: pass_step = 16'd2;
		endcase
	endfunction

endpackage

@@ rtl/gfpc_front.sv @@
// Front end: configuration registers, input acceptance, frame position
// counters and transparency decision. Depends on gfpc_pkg.
`include "assert_macros.svh"
module gfpc_front
	import gfpc_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        q_full,
	output logic        q_push,
	output queue_t      q_entry
);

	logic [15:0] left_q, top_q, width_q, height_q;
	logic        ilace_q;
	logic [1:0]  tmode_q;
	logic [7:0]  tindex_q, bgindex_q;

	logic [15:0] col_q, row_q, rows_q;
	logic [1:0]  pass_q;
	logic [15:0] col_d, row_d, rows_d;
	logic [1:0]  pass_d;

	logic        accept, is_pixel, is_load, is_start, done;
	logic [15:0] w, h, col_inc, rows_inc, row_t;
	logic [1:0]  pass_t;
	logic [7:0]  ci, lk_index;
	logic        match, we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q    <= '0;
			top_q     <= '0;
			width_q   <= 16'd1;
			height_q  <= 16'd1;
			ilace_q   <= 1'b0;
			tmode_q   <= TM_NONE;
			tindex_q  <= '0;
			bgindex_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT:      left_q    <= cfg_data;
				REG_TOP:       top_q     <= cfg_data;
				REG_WIDTH:     width_q   <= cfg_data;
				REG_HEIGHT:    height_q  <= cfg_data;
				REG_INTERLACE: ilace_q   <= cfg_data[0];
				REG_TMODE:     tmode_q   <= cfg_data[1:0];
				REG_TINDEX:    tindex_q  <= cfg_data[7:0];
				REG_BGINDEX:   bgindex_q <= cfg_data[7:0];
				default:       ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign is_load  = accept && (s_tuser == OP_LOAD);
	assign is_pixel = accept && (s_tuser == OP_PIXEL);
	assign is_start = accept && (s_tuser == OP_START);

	assign ci       = s_tdata[39:32];
	assign match    = (tmode_q != TM_NONE) && (ci == tindex_q);
	assign we       = !(match && tmode_q[TM_SKIP_BIT]);
	assign lk_index = is_load ? s_tdata[7:0] : (match ? bgindex_q : ci);

	always_comb begin
		w        = (width_q == '0) ? 16'd1 : width_q;
		h        = (height_q == '0) ? 16'd1 : height_q;
		col_inc  = col_q + 16'd1;
		rows_inc = rows_q + 16'd1;
		col_d    = col_q;
		row_d    = row_q;
		rows_d   = rows_q;
		pass_d   = pass_q;
		done     = 1'b0;
		row_t    = row_q + pass_step(pass_q);
		pass_t   = pass_q;
		// skip interlace passes that hold no rows in a short frame
		for (int k = 0; k < 3; k++) begin
			if (row_t >= h && pass_t != 2'd3) begin
				pass_t = pass_t + 2'd1;
				row_t  = pass_start(pass_t);
			end
		end
		if (is_pixel) begin
			if (col_inc >= w) begin
				col_d  = '0;
				rows_d = rows_inc;
				if (rows_inc >= h) begin
					done   = 1'b1;
					row_d  = '0;
					rows_d = '0;
					pass_d = '0;
				end else if (ilace_q) begin
					row_d  = row_t;
					pass_d = pass_t;
				end else begin
					row_d = rows_inc;
				end
			end else begin
				col_d = col_inc;
			end
		end else if (is_start) begin
			col_d  = '0;
			row_d  = '0;
			rows_d = '0;
			pass_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rows_q <= '0;
			pass_q <= '0;
		end else begin
			col_q  <= col_d;
			row_q  <= row_d;
			rows_q <= rows_d;
			pass_q <= pass_d;
		end
	end

	assign q_push = is_load || is_pixel;

	always_comb begin
		q_entry         = '0;
		q_entry.is_load = is_load;
		q_entry.index   = lk_index;
		q_entry.oob     = {1'b0, lk_index} >= 9'(PALETTE_ENTRIES);
		q_entry.rgb     = {s_tdata[31:24], s_tdata[23:16], s_tdata[15:8]};
		q_entry.we      = we;
		q_entry.pos_x   = {1'b0, left_q} + {1'b0, col_q};
		q_entry.pos_y   = {1'b0, top_q} + {1'b0, row_q};
		q_entry.done    = done;
	end

	`GFPC_ASSERT_NEXT(a_start_clears, is_start,
		col_q == '0 && row_q == '0 && rows_q == '0 && pass_q == '0,
		"start of frame left counters set")
	`GFPC_ASSERT_NEXT(a_done_clears, is_pixel && done,
		col_q == '0 && rows_q == '0 && pass_q == '0,
		"frame end left counters set")

endmodule

@@ rtl/gfpc_queue.sv @@
// Short register queue between front and back ends.
// Depends on gfpc_pkg for the entry type and depth.
`include "assert_macros.svh"
module gfpc_queue
	import gfpc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  queue_t push_data,
	output logic   full,
	input  logic   pop,
	output logic   avail,
	output queue_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	queue_t      mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full  = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign avail = cnt_q != '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	`GFPC_ASSERT(a_no_overflow, !(push && full), "push into full queue")
	`GFPC_ASSERT(a_no_underflow, !(pop && !avail), "pop from empty queue")

endmodule

@@ rtl/gfpc_back.sv @@
// Back end: palette memory, registered lookup stage and output register.
// Depends on gfpc_pkg.
module gfpc_back
	import gfpc_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_avail,
	input  queue_t      q_head,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,
	output logic [0:0]  m_tuser,
	output logic        m_tlast
);

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [23:0] pal_q [PALETTE_ENTRIES];
	logic [AW-1:0] addr;

	logic        s1_v_q, out_v_q;
	logic [23:0] rd_s1;
	queue_t      ent_s1;
	logic        s1_rdy, out_rdy;

	logic [16:0] pos_x_q, pos_y_q;
	logic [31:0] pix_q;
	logic        we_q, done_q;

	assign out_rdy = !out_v_q || m_tready;
	assign s1_rdy  = !s1_v_q || out_rdy;
	assign q_pop   = q_avail && s1_rdy;
	assign addr    = q_head.index[AW-1:0];

	// loads and lookups leave the queue in order, so a read sees every earlier load
	always_ff @(posedge clk) begin
		if (q_pop && q_head.is_load && !q_head.oob) begin
			pal_q[addr] <= q_head.rgb;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && !q_head.is_load) begin
			rd_s1  <= pal_q[addr];
			ent_s1 <= q_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_rdy) begin
				s1_v_q <= q_pop && !q_head.is_load;
			end
			if (out_rdy) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && s1_v_q) begin
			we_q    <= ent_s1.we;
			pos_x_q <= ent_s1.pos_x;
			pos_y_q <= ent_s1.pos_y;
			done_q  <= ent_s1.done;
			if (!ent_s1.we) begin
				pix_q <= '0;
			end else if (ent_s1.oob) begin
				pix_q <= 32'hFF00_0000;
			end else begin
				pix_q <= {8'hFF, rd_s1};
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'd0, pix_q, pos_y_q, pos_x_q};
	assign m_tuser  = we_q;
	assign m_tlast  = done_q;

endmodule

@@ rtl/gif_frame_pixel_compositor.sv @@
// GIF frame pixel compositor: palette expansion with frame coordinates.
// Throughput one item per cycle while the output does not stall; a pixel passes
// through the queue, the palette read register and the output register.
// Queue of four entries decouples input acceptance from the palette lookup.
// Asynchronous active-low reset clears counters, queue pointers and valids and sets
// configuration defaults; palette contents are undefined until loaded.
module gif_frame_pixel_compositor
	import gfpc_pkg::*;
#(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // palette_index, blue, green, red, color_index
	input  logic [1:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // pos_x, pos_y, pixel_value, zero pad
	output logic [0:0]  m_tuser,   // write_enable
	output logic        m_tlast    // frame_done
);

	logic   q_push, q_full, q_pop, q_avail;
	queue_t q_in, q_head;

	gfpc_front #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_in)
	);

	gfpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	gfpc_back #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_avail (q_avail),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule
